// ===== src/swb_pkg.sv =====
`default_nettype none
package swb_pkg;

  localparam int MAX_WIDTH       = 512;
  localparam int MAX_HEIGHT      = 512;
  localparam int COORD_FRAC_BITS = 8;
  localparam int COL_W           = 9;
  localparam int ROW_W           = 9;
  localparam int DIM_W           = 10;
  localparam int PIX_W           = 24;
  localparam int ADDR_W          = COL_W + ROW_W;
  localparam int STORE_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int CORDIC_STEPS    = 16;
  localparam int CORDIC_GAIN     = 19899;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_QUERY   = 1'b1;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DIV    = 10'b0000000010,
    ST_SQ     = 10'b0000000100,
    ST_SQRT   = 10'b0000001000,
    ST_OMSQ   = 10'b0000010000,
    ST_CORDIC = 10'b0000100000,
    ST_MUL    = 10'b0001000000,
    ST_SRC    = 10'b0010000000,
    ST_TAPS   = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  function automatic logic [15:0] atan_q15(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd25736;
      4'd1:    v = 16'd15193;
      4'd2:    v = 16'd8027;
      4'd3:    v = 16'd4075;
      4'd4:    v = 16'd2045;
      4'd5:    v = 16'd1024;
      4'd6:    v = 16'd512;
      4'd7:    v = 16'd256;
      4'd8:    v = 16'd128;
      4'd9:    v = 16'd64;
      4'd10:   v = 16'd32;
      4'd11:   v = 16'd16;
      4'd12:   v = 16'd8;
      4'd13:   v = 16'd4;
      4'd14:   v = 16'd2;
      default: v = 16'd1;
    endcase
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/swb_ifs.sv =====
`default_nettype none
interface swb_in_if;
  import swb_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [7:0]       red_in;
  logic [7:0]       green_in;
  logic [7:0]       blue_in;
  modport source(output valid, opcode, col, row, red_in, green_in, blue_in, input ready);
  modport sink(input valid, opcode, col, row, red_in, green_in, blue_in, output ready);
endinterface

interface swb_out_if;
  import swb_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [7:0]       red_out;
  logic [7:0]       green_out;
  logic [7:0]       blue_out;
  modport source(output valid, out_col, out_row, red_out, green_out, blue_out, input ready);
  modport sink(input valid, out_col, out_row, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

// ===== src/swb_ram.sv =====
`default_nettype none
module swb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== src/swirl_warp_bilinear.sv =====
// Write transaction: stored in the frame store at the accepting edge.
// Query inside the swirl circle: computed by a 17-step divider, 15-step square
// root, 16-step CORDIC and four taps over one RAM port.
// Query outside the circle: source pixel copied; query outside the image: zero pixel.
// One query in flight; a finished result waits in the output register.
// Synchronous reset: control idle, sizes 512; frame store not cleared.
`default_nettype none
module swirl_warp_bilinear
  import swb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  swb_in_if.sink                in_if,
  swb_out_if.source             out_if,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [DIM_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic out_valid_r;
  logic [DIM_W-1:0] w_cfg_r, h_cfg_r;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [DIM_W-1:0] w_r, h_r;
  logic [10:0] divx_rem_r, divy_rem_r;
  logic [16:0] divx_lo_r, divy_lo_r, qx_r, qy_r;
  logic [31:0] sq_r, r2_r;
  logic [30:0] sqv_r, sqres_r, sqbit_r;
  logic signed [17:0] z_r, c_r, s_r;
  logic signed [35:0] prod_r, xr_r, yr_r;
  logic [45:0] prod2_r;
  logic [COL_W-1:0] x0_r, x1_r;
  logic [ROW_W-1:0] y0_r, y1_r;
  logic [7:0] fx_r, fy_r;
  logic [16:0] wgt_r;
  logic [24:0] acc_r [3];
  logic [PIX_W-1:0] pix_r;
  logic [COL_W-1:0] oc_r;
  logic [ROW_W-1:0] or_r;
  logic [PIX_W-1:0] opix_r;

  logic in_acc, load_out;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0] ram_rdata;

  logic [11:0] remx2, remy2;
  logic [10:0] dx, dy;
  logic gex, gey;
  logic signed [17:0] xq, yq;
  logic [30:0] sq_sum;
  logic [16:0] om;
  logic [33:0] om_sq;
  logic [33:0] om_rnd;
  logic [3:0] ci;
  logic signed [17:0] dc, ds, at;
  logic signed [17:0] ma, mb;
  logic signed [36:0] xs, ys;
  logic [35:0] ux, uy;
  logic [45:0] sx_rnd;
  logic [14:0] itap;
  logic [15:0] itap1;
  logic [DIM_W-1:0] dim;
  logic [DIM_W-1:0] tap0, tap1;
  logic [8:0] wa, wb;
  logic [24:0] acc_sum [3];

  assign in_acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);
  assign w_eff = eff_size(w_cfg_r, DIM_W'(MAX_WIDTH));
  assign h_eff = eff_size(h_cfg_r, DIM_W'(MAX_HEIGHT));

  assign out_if.valid     = out_valid_r;
  assign out_if.out_col   = oc_r;
  assign out_if.out_row   = or_r;
  assign out_if.red_out   = opix_r[23:16];
  assign out_if.green_out = opix_r[15:8];
  assign out_if.blue_out  = opix_r[7:0];

  // divider step: quotient of (pos * 2^17 + size) / (2 * size)
  assign dx    = {w_r, 1'b0};
  assign dy    = {h_r, 1'b0};
  assign remx2 = {divx_rem_r, divx_lo_r[16]};
  assign remy2 = {divy_rem_r, divy_lo_r[16]};
  assign gex   = remx2 >= {1'b0, dx};
  assign gey   = remy2 >= {1'b0, dy};
  assign xq    = $signed({1'b0, qx_r}) - 18'sd32768;
  assign yq    = $signed({1'b0, qy_r}) - 18'sd32768;

  assign sq_sum = sqres_r + sqbit_r;
  assign om     = 17'd32768 - {2'b0, sqres_r[14:0]};
  assign om_sq  = {17'b0, om} * {17'b0, om};
  assign om_rnd = om_sq + 34'd16384;

  assign ci = cnt_r[3:0];
  assign dc = s_r >>> ci;
  assign ds = c_r >>> ci;
  assign at = $signed({2'b0, atan_q15(ci)});

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin ma = c_r; mb = xq; end
      2'd1:    begin ma = s_r; mb = yq; end
      2'd2:    begin ma = s_r; mb = xq; end
      default: begin ma = c_r; mb = yq; end
    endcase
  end

  assign xs = {xr_r[35], xr_r} + 37'sd1073741824;
  assign ys = {yr_r[35], yr_r} + 37'sd1073741824;
  assign ux = xs[36] ? '0 : xs[35:0];
  assign uy = ys[36] ? '0 : ys[35:0];

  assign sx_rnd = prod2_r + 46'd4194304;
  assign itap   = sx_rnd[45:31];
  assign itap1  = {1'b0, itap} + 16'd1;
  assign dim    = cnt_r[0] ? w_r : h_r;
  assign tap0   = (itap >= {5'b0, dim}) ? dim - DIM_W'(1) : itap[DIM_W-1:0];
  assign tap1   = (itap1 >= {6'b0, dim}) ? dim - DIM_W'(1) : itap1[DIM_W-1:0];

  assign wa = cnt_r[0] ? {1'b0, fx_r} : 9'd256 - {1'b0, fx_r};
  assign wb = cnt_r[1] ? {1'b0, fy_r} : 9'd256 - {1'b0, fy_r};

  for (genvar g = 0; g < 3; g++) begin : g_ch
    assign acc_sum[g] = acc_r[g] + 25'(ram_rdata[8*g +: 8] * wgt_r);
  end

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = {in_if.row, in_if.col};
    case (state_r)
      ST_IDLE: begin
        ram_we = in_acc && (in_if.opcode == OP_WRITE);
      end
      ST_TAPS: begin
        ram_addr = {cnt_r[1] ? y1_r : y0_r, cnt_r[0] ? x1_r : x0_r};
      end
      ST_SQ: begin
        ram_addr = {row_r, col_r};
      end
      default: begin
      end
    endcase
  end

  swb_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_if.red_in, in_if.green_in, in_if.blue_in}),
    .rdata (ram_rdata)
  );

  // copy path reads at the end of ST_SQ and takes the pixel in ST_OMSQ
  logic copy_r, copy_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 5'd1;
    copy_nxt  = copy_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc && in_if.opcode == OP_QUERY) begin
          if ({1'b0, in_if.col} >= w_eff || {1'b0, in_if.row} >= h_eff) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt_r == 5'd16) begin
          state_nxt = ST_SQ;
          cnt_nxt   = '0;
        end
      end
      ST_SQ: begin
        if (cnt_r == 5'd2) begin
          cnt_nxt  = '0;
          copy_nxt = r2_r >= 32'd1073741824;
          state_nxt = copy_nxt ? ST_OMSQ : ST_SQRT;
        end
      end
      ST_SQRT: begin
        copy_nxt = 1'b0;
        if (cnt_r == 5'd14) begin
          state_nxt = ST_OMSQ;
          cnt_nxt   = '0;
        end
      end
      ST_OMSQ: begin
        cnt_nxt   = '0;
        state_nxt = copy_r ? ST_DONE : ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cnt_r == 5'd15) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        if (cnt_r == 5'd4) begin
          state_nxt = ST_SRC;
          cnt_nxt   = '0;
        end
      end
      ST_SRC: begin
        if (cnt_r == 5'd2) begin
          state_nxt = ST_TAPS;
          cnt_nxt   = '0;
        end
      end
      ST_TAPS: begin
        if (cnt_r == 5'd4) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end
      end
      ST_DONE: begin
        cnt_nxt = '0;
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      copy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      w_cfg_r     <= DIM_W'(MAX_WIDTH);
      h_cfg_r     <= DIM_W'(MAX_HEIGHT);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      copy_r  <= copy_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && cfg_index == CFG_WIDTH) begin
        w_cfg_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_HEIGHT) begin
        h_cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        col_r      <= in_if.col;
        row_r      <= in_if.row;
        w_r        <= w_eff;
        h_r        <= h_eff;
        divx_rem_r <= {2'b0, in_if.col};
        divy_rem_r <= {2'b0, in_if.row};
        divx_lo_r  <= {7'b0, w_eff};
        divy_lo_r  <= {7'b0, h_eff};
        pix_r      <= '0;
      end
      ST_DIV: begin
        divx_rem_r <= gex ? 11'(remx2 - {1'b0, dx}) : remx2[10:0];
        divy_rem_r <= gey ? 11'(remy2 - {1'b0, dy}) : remy2[10:0];
        divx_lo_r  <= {divx_lo_r[15:0], 1'b0};
        divy_lo_r  <= {divy_lo_r[15:0], 1'b0};
        qx_r       <= {qx_r[15:0], gex};
        qy_r       <= {qy_r[15:0], gey};
      end
      ST_SQ: begin
        if (cnt_r == 5'd0) begin
          sq_r <= 32'(xq * xq);
        end else begin
          r2_r <= sq_r + 32'(yq * yq);
        end
        sqv_r   <= r2_r[30:0];
        sqres_r <= '0;
        sqbit_r <= 31'd1 << 28;
      end
      ST_SQRT: begin
        if (sqv_r >= sq_sum) begin
          sqv_r   <= sqv_r - sq_sum;
          sqres_r <= (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_r <= sqres_r >> 1;
        end
        sqbit_r <= sqbit_r >> 2;
      end
      ST_OMSQ: begin
        z_r <= $signed({1'b0, om_rnd[31:15]});
        c_r <= 18'sd19899;
        s_r <= '0;
        if (copy_r) begin
          pix_r <= ram_rdata;
        end
      end
      ST_CORDIC: begin
        if (!z_r[17]) begin
          c_r <= c_r - dc;
          s_r <= s_r + ds;
          z_r <= z_r - at;
        end else begin
          c_r <= c_r + dc;
          s_r <= s_r - ds;
          z_r <= z_r + at;
        end
      end
      ST_MUL: begin
        prod_r <= ma * mb;
        case (cnt_r[2:0])
          3'd1:    xr_r <= prod_r;
          3'd2:    xr_r <= xr_r - prod_r;
          3'd3:    yr_r <= prod_r;
          3'd4:    yr_r <= yr_r + prod_r;
          default: begin
          end
        endcase
      end
      ST_SRC: begin
        if (cnt_r == 5'd0) begin
          prod2_r <= 46'(ux * w_r);
        end else if (cnt_r == 5'd1) begin
          prod2_r <= 46'(uy * h_r);
          x0_r    <= tap0[COL_W-1:0];
          x1_r    <= tap1[COL_W-1:0];
          fx_r    <= sx_rnd[30:23];
        end else begin
          y0_r    <= tap0[ROW_W-1:0];
          y1_r    <= tap1[ROW_W-1:0];
          fy_r    <= sx_rnd[30:23];
        end
      end
      ST_TAPS: begin
        wgt_r <= 17'(wa * wb);
        for (int k = 0; k < 3; k++) begin
          acc_r[k] <= (cnt_r == 5'd0) ? '0 : acc_sum[k];
        end
        if (cnt_r == 5'd4) begin
          for (int k = 0; k < 3; k++) begin
            pix_r[8*k +: 8] <= 8'((acc_sum[k] + 25'd32768) >> (2 * COORD_FRAC_BITS));
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          oc_r   <= col_r;
          or_r   <= row_r;
          opix_r <= pix_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE)
    else $error("frame store written outside idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(state_r == ST_DONE))
    else $error("result raised without a finished query");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !out_valid_r |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished query not moved to output");

endmodule
`default_nettype wire
